[rtl/rra_pkg.sv]
// ----------------------------------------------------------------------------
// rra_pkg: shared types and constants of the range rule automaton
// Operation codes, field widths and the packed layout of one rule entry.
// ----------------------------------------------------------------------------
package rra_pkg;

  localparam int OP_W    = 3;
  localparam int STATE_W = 4;
  localparam int SYM_W   = 8;
  localparam int LEN_W   = 9;
  localparam int IDX_W   = 8;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic [STATE_W-1:0] BEGIN_STATE = 4'd0;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [STATE_W-1:0] state_idx_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // One entry of the rule table, 25 bits.
  typedef struct packed {
    state_idx_t from_st;
    sym_t       low;
    sym_t       high;
    state_idx_t to_st;
    logic       acc;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

endpackage

[rtl/rra_if.sv]
// ----------------------------------------------------------------------------
// rra_in_if / rra_out_if: transaction channels of the range rule automaton
// Valid/ready channels that carry one command or one result per transaction.
// ----------------------------------------------------------------------------
interface rra_in_if;
  logic                valid;
  logic                ready;
  rra_pkg::op_t        operation;
  rra_pkg::sym_t       symbol;
  rra_pkg::state_idx_t rule_from;
  rra_pkg::sym_t       rule_low;
  rra_pkg::sym_t       rule_high;
  rra_pkg::state_idx_t rule_to;
  logic                rule_accepting;
  rra_pkg::idx_t       read_index;

  modport source (
    output valid, operation, symbol, rule_from, rule_low, rule_high, rule_to,
           rule_accepting, read_index,
    input  ready
  );
  modport sink (
    input  valid, operation, symbol, rule_from, rule_low, rule_high, rule_to,
           rule_accepting, read_index,
    output ready
  );
endinterface

interface rra_out_if;
  logic                valid;
  logic                ready;
  logic                taken;
  rra_pkg::state_idx_t current_state;
  logic                accepting;
  rra_pkg::len_t       token_length;
  rra_pkg::sym_t       read_byte;
  logic                overflow;

  modport source (
    output valid, taken, current_state, accepting, token_length, read_byte,
           overflow,
    input  ready
  );
  modport sink (
    input  valid, taken, current_state, accepting, token_length, read_byte,
           overflow,
    output ready
  );
endinterface

[rtl/rra_ram.sv]
// ----------------------------------------------------------------------------
// rra_ram: generic single-write, single-read memory
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module rra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/range_rule_automaton_unit.sv]
// ----------------------------------------------------------------------------
// range_rule_automaton_unit: programmable automaton with byte range rules
// Rules are loaded in order; a pushed byte fires the first matching rule,
// moves the state and appends the byte to the token buffer if not full; a miss empties it.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   in_ch    sink       operation, symbol, new rule fields, read index
//   out_ch   source     taken, state, accepting mark, token length, byte, overflow
//
// A push with an empty table goes straight to the final step; else it scans the
// rules in load order up to the first matching rule (or to the last rule on a
// miss): one shared range comparator checks one rule per cycle out of the
// rule RAM. A read within the token length passes through a step that waits
// on the token RAM; every other command, a read past the end included, goes
// straight to the final step. The result register frees in_ch once it is loaded;
// a stalled out_ch holds the next result in the final step. Reset is synchronous and needs no pass.
module range_rule_automaton_unit #(
  parameter int NUM_STATES = 16,
  parameter int MAX_RULES  = 32,
  parameter int MAX_TOKEN  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  rra_in_if.sink     in_ch,
  rra_out_if.source  out_ch
);

  localparam int RAW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RCW  = $clog2(MAX_RULES + 1);
  localparam int TAW  = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
  localparam int TCW  = $clog2(MAX_TOKEN + 1);
  localparam int XW   = (TCW > rra_pkg::IDX_W) ? TCW : rra_pkg::IDX_W;
  localparam int LW   = (TCW > rra_pkg::LEN_W) ? TCW : rra_pkg::LEN_W;
  localparam logic [4:0] NS_MOD = (NUM_STATES >= 16) ? 5'd16 : 5'(NUM_STATES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // State indices fold into the state count by repeated subtraction.
  function automatic rra_pkg::state_idx_t st_mod(input rra_pkg::state_idx_t x);
    logic [4:0] v;
    v = {1'b0, x};
    for (int k = 0; k < 8; k++) begin
      if (v >= NS_MOD) begin
        v = v - NS_MOD;
      end
    end
    return v[3:0];
  endfunction

  logic [1:0]          fsm_r, fsm_nxt;
  logic [RAW-1:0]      idx_r, idx_nxt;
  logic [RCW-1:0]      rule_cnt_r, rule_cnt_nxt;
  logic [TCW-1:0]      tok_cnt_r, tok_cnt_nxt;
  rra_pkg::state_idx_t cur_st_r, cur_st_nxt;
  logic                acc_r, acc_nxt;
  rra_pkg::sym_t       sym_r, sym_nxt;
  logic                res_taken_r, res_taken_nxt;
  rra_pkg::sym_t       res_rbyte_r, res_rbyte_nxt;
  logic                res_ovf_r, res_ovf_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_taken_r, out_taken_nxt;
  rra_pkg::state_idx_t out_st_r, out_st_nxt;
  logic                out_acc_r, out_acc_nxt;
  rra_pkg::len_t       out_len_r, out_len_nxt;
  rra_pkg::sym_t       out_rbyte_r, out_rbyte_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                rule_we;
  logic [RAW-1:0]      rule_waddr;
  rra_pkg::rule_t      rule_wdata;
  logic [RAW-1:0]      rule_raddr;
  rra_pkg::rule_t      rule_rdata;

  logic                tok_we;
  logic [TAW-1:0]      tok_waddr;
  logic [TAW-1:0]      tok_raddr;
  rra_pkg::sym_t       tok_rdata;

  logic                accept;
  logic                rule_hit;
  logic [RCW-1:0]      idx_inc;
  logic [XW-1:0]       rd_idx_ext;
  logic [LW-1:0]       len_ext;

  rra_ram #(.WIDTH(rra_pkg::RULE_W), .DEPTH(MAX_RULES)) u_rule_ram (
    .clk     (clk),
    .wr_en   (rule_we),
    .wr_addr (rule_waddr),
    .wr_data (rule_wdata),
    .rd_addr (rule_raddr),
    .rd_data (rule_rdata)
  );

  rra_ram #(.WIDTH(rra_pkg::SYM_W), .DEPTH(MAX_TOKEN)) u_tok_ram (
    .clk     (clk),
    .wr_en   (tok_we),
    .wr_addr (tok_waddr),
    .wr_data (sym_r),
    .rd_addr (tok_raddr),
    .rd_data (tok_rdata)
  );

  assign in_ch.ready = (fsm_r == ST_IDLE);
  assign accept      = in_ch.valid && (fsm_r == ST_IDLE);

  // The rule RAM is read one entry ahead of the comparator.
  assign idx_inc    = RCW'(idx_r) + RCW'(1);
  assign rule_raddr = (fsm_r == ST_IDLE) ? '0 : idx_inc[RAW-1:0];
  assign rule_hit   = (rule_rdata.from_st == cur_st_r) &&
                      (sym_r >= rule_rdata.low) && (sym_r <= rule_rdata.high);

  assign rd_idx_ext = XW'(in_ch.read_index);
  assign tok_raddr  = rd_idx_ext[TAW-1:0];
  assign tok_waddr  = tok_cnt_r[TAW-1:0];
  assign len_ext    = LW'(tok_cnt_r);

  always_comb begin
    fsm_nxt       = fsm_r;
    idx_nxt       = idx_r;
    rule_cnt_nxt  = rule_cnt_r;
    tok_cnt_nxt   = tok_cnt_r;
    cur_st_nxt    = cur_st_r;
    acc_nxt       = acc_r;
    sym_nxt       = sym_r;
    res_taken_nxt = res_taken_r;
    res_rbyte_nxt = res_rbyte_r;
    res_ovf_nxt   = res_ovf_r;
    rule_we       = 1'b0;
    rule_waddr    = rule_cnt_r[RAW-1:0];
    rule_wdata    = '{from_st: st_mod(in_ch.rule_from), low: in_ch.rule_low,
                      high: in_ch.rule_high, to_st: st_mod(in_ch.rule_to),
                      acc: in_ch.rule_accepting};
    tok_we        = 1'b0;

    case (fsm_r)
      ST_IDLE: begin
        if (accept) begin
          res_taken_nxt = 1'b0;
          res_rbyte_nxt = '0;
          res_ovf_nxt   = 1'b0;
          fsm_nxt       = ST_DONE;
          case (in_ch.operation)
            rra_pkg::OP_PUSH: begin
              sym_nxt = in_ch.symbol;
              idx_nxt = '0;
              if (rule_cnt_r == '0) begin
                tok_cnt_nxt = '0;
              end else begin
                fsm_nxt = ST_SCAN;
              end
            end
            rra_pkg::OP_ADD: begin
              if (rule_cnt_r < RCW'(MAX_RULES)) begin
                rule_we      = 1'b1;
                rule_cnt_nxt = rule_cnt_r + RCW'(1);
              end else begin
                res_ovf_nxt = 1'b1;
              end
            end
            rra_pkg::OP_RESTART: begin
              cur_st_nxt  = rra_pkg::BEGIN_STATE;
              acc_nxt     = 1'b0;
              tok_cnt_nxt = '0;
            end
            rra_pkg::OP_CLEAR: begin
              cur_st_nxt   = rra_pkg::BEGIN_STATE;
              acc_nxt      = 1'b0;
              tok_cnt_nxt  = '0;
              rule_cnt_nxt = '0;
            end
            rra_pkg::OP_READ: begin
              if (rd_idx_ext < XW'(tok_cnt_r)) begin
                fsm_nxt = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rule_hit) begin
          cur_st_nxt    = rule_rdata.to_st;
          acc_nxt       = rule_rdata.acc;
          res_taken_nxt = 1'b1;
          if (tok_cnt_r < TCW'(MAX_TOKEN)) begin
            tok_we      = 1'b1;
            tok_cnt_nxt = tok_cnt_r + TCW'(1);
          end else begin
            res_ovf_nxt = 1'b1;
          end
          fsm_nxt = ST_DONE;
        end else if (idx_inc == rule_cnt_r) begin
          tok_cnt_nxt = '0;
          fsm_nxt     = ST_DONE;
        end else begin
          idx_nxt = idx_inc[RAW-1:0];
        end
      end
      ST_READ: begin
        res_rbyte_nxt = tok_rdata;
        fsm_nxt       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          fsm_nxt = ST_IDLE;
        end
      end
      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_taken_nxt = out_taken_r;
    out_st_nxt    = out_st_r;
    out_acc_nxt   = out_acc_r;
    out_len_nxt   = out_len_r;
    out_rbyte_nxt = out_rbyte_r;
    out_ovf_nxt   = out_ovf_r;
    if ((fsm_r == ST_DONE) && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt = 1'b1;
      out_taken_nxt = res_taken_r;
      out_st_nxt    = cur_st_r;
      out_acc_nxt   = acc_r;
      out_len_nxt   = len_ext[rra_pkg::LEN_W-1:0];
      out_rbyte_nxt = res_rbyte_r;
      out_ovf_nxt   = res_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      rule_cnt_r  <= '0;
      tok_cnt_r   <= '0;
      cur_st_r    <= rra_pkg::BEGIN_STATE;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      rule_cnt_r  <= rule_cnt_nxt;
      tok_cnt_r   <= tok_cnt_nxt;
      cur_st_r    <= cur_st_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    sym_r       <= sym_nxt;
    res_taken_r <= res_taken_nxt;
    res_rbyte_r <= res_rbyte_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_taken_r <= out_taken_nxt;
    out_st_r    <= out_st_nxt;
    out_acc_r   <= out_acc_nxt;
    out_len_r   <= out_len_nxt;
    out_rbyte_r <= out_rbyte_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.taken         = out_taken_r;
  assign out_ch.current_state = out_st_r;
  assign out_ch.accepting     = out_acc_r;
  assign out_ch.token_length  = out_len_r;
  assign out_ch.read_byte     = out_rbyte_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

[rtl/rra_checker.sv]
// ----------------------------------------------------------------------------
// rra_checker: port-level checks of the range rule automaton
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module rra_checker (
  input logic       clk,
  input logic       rst_n,
  rra_in_if.sink    in_ch,
  rra_out_if.source out_ch
);

  // A result waiting on a stalled sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      $stable(out_ch.taken) && $stable(out_ch.current_state) &&
      $stable(out_ch.token_length) && $stable(out_ch.read_byte))
    else $error("result payload changed while stalled");

  // Every accepted command takes the sequencer out of idle, so in_ch drops ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("command accepted while the previous one is in progress");

  // Only a read returns a byte, and a read never reports taken or overflow.
  a_read_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.read_byte != 8'd0) |-> !out_ch.taken && !out_ch.overflow)
    else $error("read byte reported together with push or store status");

  // A stored byte leaves the token buffer non-empty.
  a_taken_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.taken && !out_ch.overflow |-> out_ch.token_length != 9'd0)
    else $error("byte stored but token length is zero");

endmodule

bind range_rule_automaton_unit rra_checker u_rra_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

[tb/tb_range_rule_automaton_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_rule_automaton_unit: self-checking bench for the range automaton
// Drives commands over the input channel with random gaps, keeps its own copy
// of the rule table, state and token buffer to predict every result, and
// compares each result transaction field by field under random back-pressure.
// ----------------------------------------------------------------------------
module tb_range_rule_automaton_unit;

  localparam int NUM_STATES   = 16;
  localparam int NUM_RULES    = 32;
  localparam int TOKEN_DEPTH  = 256;
  localparam int ITEM_TARGET  = 1450;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  localparam rra_pkg::op_t        OP_RSVD_FIRST = 3'd5;
  localparam rra_pkg::op_t        OP_RSVD_LAST  = 3'd7;
  localparam rra_pkg::state_idx_t PARKED_STATE  = 4'd9;

  typedef struct {
    rra_pkg::op_t        op;
    rra_pkg::sym_t       sym;
    rra_pkg::state_idx_t from_st;
    rra_pkg::sym_t       low;
    rra_pkg::sym_t       high;
    rra_pkg::state_idx_t to_st;
    logic                acc;
    rra_pkg::idx_t       rd_idx;
  } cmd_t;

  typedef struct {
    logic                taken;
    rra_pkg::state_idx_t st;
    logic                acc;
    rra_pkg::len_t       len;
    rra_pkg::sym_t       rbyte;
    logic                ovf;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;

  rra_in_if  in_ch ();
  rra_out_if out_ch ();

  range_rule_automaton_unit #(
    .NUM_STATES(NUM_STATES),
    .MAX_RULES (NUM_RULES),
    .MAX_TOKEN (TOKEN_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the automaton.
  rra_pkg::state_idx_t fsm_state  = rra_pkg::BEGIN_STATE;
  logic                cur_accept = 1'b0;
  rra_pkg::rule_t      rule_tab [NUM_RULES];
  int                  rule_total = 0;
  rra_pkg::sym_t       tok_buf [TOKEN_DEPTH];
  int                  tok_len    = 0;

  status_t pending_status [$];
  int      items_sent     = 0;
  int      results_seen   = 0;
  int      mismatches     = 0;
  bit      no_gaps        = 1'b0;
  int      stall_left     = 0;
  status_t want, got;

  function automatic status_t next_status(input cmd_t c);
    status_t r;
    bit      hit;
    r   = '{default: '0};
    hit = 1'b0;
    case (c.op)
      rra_pkg::OP_PUSH: begin
        // The first rule in load order wins.
        for (int i = 0; i < rule_total; i++) begin
          if (!hit && rule_tab[i].from_st == fsm_state &&
              c.sym >= rule_tab[i].low && c.sym <= rule_tab[i].high) begin
            fsm_state  = rule_tab[i].to_st;
            cur_accept = rule_tab[i].acc;
            hit        = 1'b1;
          end
        end
        if (hit) begin
          r.taken = 1'b1;
          if (tok_len < TOKEN_DEPTH) begin
            tok_buf[tok_len] = c.sym;
            tok_len++;
          end else begin
            r.ovf = 1'b1;
          end
        end else begin
          tok_len = 0;
        end
      end
      rra_pkg::OP_ADD: begin
        if (rule_total < NUM_RULES) begin
          rule_tab[rule_total] =
            '{from_st: rra_pkg::state_idx_t'(c.from_st % NUM_STATES),
              low: c.low, high: c.high,
              to_st: rra_pkg::state_idx_t'(c.to_st % NUM_STATES),
              acc: c.acc};
          rule_total++;
        end else begin
          r.ovf = 1'b1;
        end
      end
      rra_pkg::OP_RESTART, rra_pkg::OP_CLEAR: begin
        fsm_state  = rra_pkg::BEGIN_STATE;
        cur_accept = 1'b0;
        tok_len    = 0;
        if (c.op == rra_pkg::OP_CLEAR) rule_total = 0;
      end
      rra_pkg::OP_READ: begin
        if (c.rd_idx < tok_len) r.rbyte = tok_buf[c.rd_idx];
      end
      default: ;
    endcase
    r.st  = fsm_state;
    r.acc = cur_accept;
    r.len = rra_pkg::len_t'(tok_len);
    return r;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic rra_pkg::state_idx_t pick_state();
    if ($urandom_range(0, 7) == 0) return rra_pkg::state_idx_t'($urandom_range(0, 15));
    return rra_pkg::state_idx_t'($urandom_range(0, 3));
  endfunction

  // Every field gets random content, then the helpers fix what matters.
  function automatic cmd_t rand_cmd(input rra_pkg::op_t op);
    cmd_t c;
    c.op      = op;
    c.sym     = rra_pkg::sym_t'($urandom_range(0, 255));
    c.from_st = rra_pkg::state_idx_t'($urandom_range(0, 15));
    c.low     = rra_pkg::sym_t'($urandom_range(0, 255));
    c.high    = rra_pkg::sym_t'($urandom_range(0, 255));
    c.to_st   = rra_pkg::state_idx_t'($urandom_range(0, 15));
    c.acc     = logic'($urandom_range(0, 1));
    c.rd_idx  = rra_pkg::idx_t'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic cmd_t push_cmd(input rra_pkg::sym_t s);
    cmd_t c;
    c     = rand_cmd(rra_pkg::OP_PUSH);
    c.sym = s;
    return c;
  endfunction

  function automatic cmd_t rule_cmd(input rra_pkg::state_idx_t f,
                                    input rra_pkg::sym_t lo, input rra_pkg::sym_t hi,
                                    input rra_pkg::state_idx_t t, input logic a);
    cmd_t c;
    c         = rand_cmd(rra_pkg::OP_ADD);
    c.from_st = f;
    c.low     = lo;
    c.high    = hi;
    c.to_st   = t;
    c.acc     = a;
    return c;
  endfunction

  function automatic cmd_t read_cmd(input rra_pkg::idx_t idx);
    cmd_t c;
    c        = rand_cmd(rra_pkg::OP_READ);
    c.rd_idx = idx;
    return c;
  endfunction

  function automatic cmd_t random_rule();
    rra_pkg::sym_t lo, hi;
    int            shape;
    shape = $urandom_range(0, 9);
    lo    = rra_pkg::sym_t'($urandom_range(0, 255));
    if (shape == 0) begin
      lo = 8'h00;
      hi = 8'hFF;
    end else if (shape == 1) begin
      hi = rra_pkg::sym_t'($urandom_range(0, 255));
    end else begin
      hi = (lo > 8'd191) ? 8'hFF : rra_pkg::sym_t'(lo + $urandom_range(0, 63));
    end
    return rule_cmd(pick_state(), lo, hi, pick_state(), logic'($urandom_range(0, 1)));
  endfunction

  // Picks a byte that some rule of the current state accepts, when one exists.
  function automatic rra_pkg::sym_t match_symbol();
    int cand [$];
    int k;
    for (int i = 0; i < rule_total; i++) begin
      if (rule_tab[i].from_st == fsm_state && rule_tab[i].low <= rule_tab[i].high)
        cand.push_back(i);
    end
    if (cand.size() == 0) return rra_pkg::sym_t'($urandom_range(0, 255));
    k = cand[$urandom_range(0, cand.size() - 1)];
    return rra_pkg::sym_t'($urandom_range(rule_tab[k].low, rule_tab[k].high));
  endfunction

  // Called right after a rising edge; valid stays high on return.
  task automatic issue_cmd(input cmd_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= c.op;
    in_ch.symbol         <= c.sym;
    in_ch.rule_from      <= c.from_st;
    in_ch.rule_low       <= c.low;
    in_ch.rule_high      <= c.high;
    in_ch.rule_to        <= c.to_st;
    in_ch.rule_accepting <= c.acc;
    in_ch.read_index     <= c.rd_idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_status.push_back(next_status(c));
    items_sent++;
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ERROR: %s", $time, msg);
  endtask

  // Result side: random stalls per transaction, one check per transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{taken: out_ch.taken, st: out_ch.current_state, acc: out_ch.accepting,
                len: out_ch.token_length, rbyte: out_ch.read_byte, ovf: out_ch.overflow};
        if (pending_status.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no command pending", results_seen));
        end else begin
          want = pending_status.pop_front();
          if (got.taken !== want.taken || got.st !== want.st || got.acc !== want.acc ||
              got.len !== want.len || got.rbyte !== want.rbyte || got.ovf !== want.ovf)
            flag_error($sformatf({"result %0d: expected taken=%0b state=%0d acc=%0b ",
                                  "len=%0d byte=%02h ovf=%0b, got taken=%0b state=%0d ",
                                  "acc=%0b len=%0d byte=%02h ovf=%0b"},
                                 results_seen, want.taken, want.st, want.acc, want.len,
                                 want.rbyte, want.ovf, got.taken, got.st, got.acc,
                                 got.len, got.rbyte, got.ovf));
        end
        results_seen++;
        stall_left = draw_gap();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // Every operation at least once, first-match order, empty ranges, misses and reads.
  task automatic test_basic_ops();
    no_gaps = 1'b0;
    issue_cmd(push_cmd(8'hFF));
    issue_cmd(read_cmd(8'h00));
    issue_cmd(rule_cmd(rra_pkg::BEGIN_STATE, 8'h30, 8'h39, 4'd1, 1'b1));
    issue_cmd(rule_cmd(4'd1, 8'h00, 8'hFF, 4'd15, 1'b0));
    issue_cmd(rule_cmd(4'd15, 8'hC8, 8'h64, rra_pkg::BEGIN_STATE, 1'b1));
    issue_cmd(rule_cmd(4'd15, 8'h00, 8'h00, rra_pkg::BEGIN_STATE, 1'b1));
    issue_cmd(rule_cmd(rra_pkg::BEGIN_STATE, 8'h00, 8'hFF, 4'd2, 1'b0));
    issue_cmd(push_cmd(8'h35));
    issue_cmd(push_cmd(8'hFF));
    issue_cmd(push_cmd(8'h90));
    issue_cmd(push_cmd(8'h00));
    issue_cmd(push_cmd(8'h41));
    issue_cmd(read_cmd(8'h00));
    issue_cmd(read_cmd(8'h01));
    issue_cmd(read_cmd(8'h02));
    issue_cmd(read_cmd(8'hFF));
    issue_cmd(push_cmd(8'h7A));
    issue_cmd(rand_cmd(rra_pkg::OP_RESTART));
    issue_cmd(rand_cmd(rra_pkg::OP_CLEAR));
    issue_cmd(push_cmd(8'h30));
  endtask

  task automatic test_unused_codes();
    no_gaps = 1'b1;
    issue_cmd(rule_cmd(rra_pkg::BEGIN_STATE, 8'h00, 8'hFF, 4'd3, 1'b1));
    issue_cmd(push_cmd(8'hA5));
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
      issue_cmd(rand_cmd(rra_pkg::op_t'(op)));
    issue_cmd(read_cmd(8'h00));
  endtask

  // Only the last slot matches from the begin state, so each push scans the
  // whole table; the adds beyond it must report overflow.
  task automatic test_rule_table_full();
    cmd_t c;
    no_gaps = 1'b0;
    issue_cmd(rand_cmd(rra_pkg::OP_CLEAR));
    for (int i = 0; i < NUM_RULES - 1; i++) begin
      c         = random_rule();
      c.from_st = PARKED_STATE;
      issue_cmd(c);
    end
    issue_cmd(rule_cmd(rra_pkg::BEGIN_STATE, 8'h00, 8'hFF, rra_pkg::BEGIN_STATE, 1'b0));
    issue_cmd(random_rule());
    issue_cmd(random_rule());
    repeat (6) issue_cmd(push_cmd(rra_pkg::sym_t'($urandom_range(0, 255))));
  endtask

  task automatic test_token_buffer_full();
    issue_cmd(rand_cmd(rra_pkg::OP_CLEAR));
    issue_cmd(rule_cmd(rra_pkg::BEGIN_STATE, 8'h00, 8'hFF, rra_pkg::BEGIN_STATE, 1'b1));
    for (int i = 0; i < TOKEN_DEPTH + 3; i++) begin
      if (i % 32 == 0) no_gaps = bit'($urandom_range(0, 1));
      issue_cmd(push_cmd(rra_pkg::sym_t'($urandom_range(0, 255))));
    end
    issue_cmd(read_cmd(8'hFF));
    issue_cmd(read_cmd(8'h00));
    issue_cmd(read_cmd(rra_pkg::idx_t'($urandom_range(0, 255))));
    issue_cmd(rand_cmd(rra_pkg::OP_RESTART));
    issue_cmd(read_cmd(8'h00));
  endtask

  // Sessions: load an automaton, mostly a small one, then walk it with mostly matching bytes.
  task automatic test_random_sessions();
    int n_rules, n_steps, pick;
    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      issue_cmd(rand_cmd(($urandom_range(0, 3) == 0) ? rra_pkg::OP_RESTART
                                                      : rra_pkg::OP_CLEAR));
      n_rules = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 34) : $urandom_range(1, 10);
      repeat (n_rules) issue_cmd(random_rule());
      n_steps = $urandom_range(15, 50);
      repeat (n_steps) begin
        pick = $urandom_range(0, 19);
        if (pick < 13)
          issue_cmd(push_cmd(match_symbol()));
        else if (pick < 15)
          issue_cmd(push_cmd(rra_pkg::sym_t'($urandom_range(0, 255))));
        else if (pick < 17)
          issue_cmd(read_cmd((tok_len > 0 && $urandom_range(0, 3) != 0) ?
                             rra_pkg::idx_t'($urandom_range(0, tok_len - 1)) :
                             rra_pkg::idx_t'($urandom_range(0, 255))));
        else if (pick == 17)
          issue_cmd(rand_cmd(rra_pkg::OP_RESTART));
        else if (pick == 18)
          issue_cmd(rand_cmd(rra_pkg::op_t'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST))));
        else
          issue_cmd(random_rule());
      end
    end
  endtask

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_range_rule_automaton_unit NOT OK");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = rra_pkg::OP_PUSH;
    in_ch.symbol         = '0;
    in_ch.rule_from      = '0;
    in_ch.rule_low       = '0;
    in_ch.rule_high      = '0;
    in_ch.rule_to        = '0;
    in_ch.rule_accepting = 1'b0;
    in_ch.read_index     = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_unused_codes();
    test_rule_table_full();
    test_token_buffer_full();
    test_random_sessions();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_range_rule_automaton_unit OK");
    end else begin
      $display("tb_range_rule_automaton_unit NOT OK");
    end
    $finish;
  end

endmodule
